>>> rtl/afk_pkg.sv
// Shared constants, link table and rounding helper for the seven-joint kinematics block
`timescale 1ns / 1ps
package afk_pkg;

    // Field widths of the item ports
    localparam int ANGLE_W = 18;
    localparam int OUT_W   = 18;

    // Angles and unity at 30 fraction bits
    localparam longint Q30_ONE        = 64'sd1073741824;
    localparam longint Q30_HALF_PI    = 64'sd1686629713;
    localparam longint Q30_QUARTER_PI = 64'sd843314857;
    localparam longint Q30_HAND_TURN  = -64'sd842887332;

    // Chain: seven joints, flange frame, hand frame
    localparam int NUM_JOINTS = 7;
    localparam int NUM_LINKS  = 9;
    localparam int LINK_HAND  = 8;

    // Per-link constants: offset a, length d (30 fraction bits), sine and cosine of the twist
    localparam longint LINK_A_Q30 [NUM_LINKS] = '{
        0, 0, 0, 88583700, -88583700, 0, 94489281, 0, 0
    };
    localparam longint LINK_D_Q30 [NUM_LINKS] = '{
        357556027, 0, 339302416, 0, 412316860, 0, 0, 114890375, 110595408
    };
    localparam int LINK_SA [NUM_LINKS] = '{0, -1, 1, 1, -1, 1, 1, 0, 0};
    localparam int LINK_CA [NUM_LINKS] = '{1, 0, 0, 0, 0, 0, 0, 1, 1};

    // Series divisors, n(n+1) for the sine and cosine terms
    localparam int SERIES_TERMS = 7;
    localparam int SIN_DIV [SERIES_TERMS] = '{6, 20, 42, 72, 110, 156, 210};
    localparam int COS_DIV [SERIES_TERMS] = '{2, 12, 30, 56, 90, 132, 182};

    // Pipeline depths
    localparam int STEP_LAT = 3;
    localparam int TRIG_LAT = 3 + STEP_LAT * SERIES_TERMS;
    localparam int CELL_LAT = 2;

    // Register map
    localparam int REG_TOOL_EN = 0;

    // Shift right by s with round to nearest, ties away from zero
    function automatic logic signed [63:0] round_shift64(input logic signed [63:0] x,
                                                         input int unsigned s);
        logic [63:0]        mag;
        logic signed [63:0] res;
        if (s == 0)
        begin
            res = x;
        end
        else
        begin
            mag = (x < 0) ? 64'(-x) : 64'(x);
            mag = (mag + (64'd1 << (s - 1))) >> s;
            res = (x < 0) ? -$signed(mag) : $signed(mag);
        end
        return res;
    endfunction

endpackage

>>> rtl/afk_joint_if.sv
// Joint angle item channel
`timescale 1ns / 1ps
interface afk_joint_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [afk_pkg::ANGLE_W-1:0]  joint_1_angle;
    logic signed [afk_pkg::ANGLE_W-1:0]  joint_2_angle;
    logic signed [afk_pkg::ANGLE_W-1:0]  joint_3_angle;
    logic signed [afk_pkg::ANGLE_W-1:0]  joint_4_angle;
    logic signed [afk_pkg::ANGLE_W-1:0]  joint_5_angle;
    logic signed [afk_pkg::ANGLE_W-1:0]  joint_6_angle;
    logic signed [afk_pkg::ANGLE_W-1:0]  joint_7_angle;

    modport source (
        output valid, joint_1_angle, joint_2_angle, joint_3_angle, joint_4_angle,
               joint_5_angle, joint_6_angle, joint_7_angle,
        input  ready
    );
    modport sink (
        input  valid, joint_1_angle, joint_2_angle, joint_3_angle, joint_4_angle,
               joint_5_angle, joint_6_angle, joint_7_angle,
        output ready
    );
endinterface

>>> rtl/afk_pose_if.sv
// End frame pose item channel
`timescale 1ns / 1ps
interface afk_pose_if;
    logic                               valid;
    logic                               ready;
    logic signed [afk_pkg::OUT_W-1:0]  rot_row0_col0;
    logic signed [afk_pkg::OUT_W-1:0]  rot_row0_col1;
    logic signed [afk_pkg::OUT_W-1:0]  rot_row0_col2;
    logic signed [afk_pkg::OUT_W-1:0]  rot_row1_col0;
    logic signed [afk_pkg::OUT_W-1:0]  rot_row1_col1;
    logic signed [afk_pkg::OUT_W-1:0]  rot_row1_col2;
    logic signed [afk_pkg::OUT_W-1:0]  rot_row2_col0;
    logic signed [afk_pkg::OUT_W-1:0]  rot_row2_col1;
    logic signed [afk_pkg::OUT_W-1:0]  rot_row2_col2;
    logic signed [afk_pkg::OUT_W-1:0]  pos_x;
    logic signed [afk_pkg::OUT_W-1:0]  pos_y;
    logic signed [afk_pkg::OUT_W-1:0]  pos_z;

    modport source (
        output valid, rot_row0_col0, rot_row0_col1, rot_row0_col2, rot_row1_col0,
               rot_row1_col1, rot_row1_col2, rot_row2_col0, rot_row2_col1,
               rot_row2_col2, pos_x, pos_y, pos_z,
        input  ready
    );
    modport sink (
        input  valid, rot_row0_col0, rot_row0_col1, rot_row0_col2, rot_row1_col0,
               rot_row1_col1, rot_row1_col2, rot_row2_col0, rot_row2_col1,
               rot_row2_col2, pos_x, pos_y, pos_z,
        output ready
    );
endinterface

>>> rtl/afk_series_step.sv
// One Taylor series term: multiply by x^2, round, exact divide by a constant, accumulate
`timescale 1ns / 1ps
module afk_series_step #(
    parameter int DIV = 6
) (
    input  logic               clk,
    input  logic               en,
    input  logic signed [32:0] term_in,
    input  logic signed [33:0] acc_in,
    input  logic        [30:0] x2_in,
    output logic signed [32:0] term_out,
    output logic signed [33:0] acc_out,
    output logic        [30:0] x2_out
);

    // Reciprocal for an exact floor divide of a 31-bit magnitude
    localparam int          SH    = 31 + $clog2(DIV);
    localparam logic [63:0] MAGIC = ((64'd1 << SH) + 64'(DIV) - 64'd1) / 64'(DIV);

    logic [31:0]        magic32;
    logic signed [64:0] prod_reg;
    logic signed [33:0] acc_a_reg;
    logic        [30:0] x2_a_reg;
    logic        [64:0] abs_p;
    logic        [31:0] mag;
    logic        [63:0] mm_reg;
    logic               neg_reg;
    logic signed [33:0] acc_b_reg;
    logic        [30:0] x2_b_reg;
    logic signed [32:0] quo;
    logic signed [32:0] term_next;
    logic signed [32:0] term_reg;
    logic signed [33:0] acc_reg;
    logic        [30:0] x2_reg;

    assign magic32 = MAGIC[31:0];

    // Stage a: term times x^2
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg  <= 65'(term_in) * 65'($signed({1'b0, x2_in}));
            acc_a_reg <= acc_in;
            x2_a_reg  <= x2_in;
        end
    end

    // Stage b: round to 30 fraction bits, magnitude times reciprocal
    assign abs_p = prod_reg[64] ? 65'(-prod_reg) : 65'(prod_reg);
    assign mag   = 32'((abs_p + 65'd536870912) >> 30);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mm_reg    <= 64'(mag) * 64'(magic32);
            neg_reg   <= prod_reg[64];
            acc_b_reg <= acc_a_reg;
            x2_b_reg  <= x2_a_reg;
        end
    end

    // Stage c: quotient truncates toward zero, term alternates sign
    assign quo       = 33'(mm_reg >> SH);
    assign term_next = neg_reg ? quo : -quo;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            term_reg <= term_next;
            acc_reg  <= acc_b_reg + 34'(term_next);
            x2_reg   <= x2_b_reg;
        end
    end

    assign term_out = term_reg;
    assign acc_out  = acc_reg;
    assign x2_out   = x2_reg;

endmodule

>>> rtl/afk_sincos.sv
// Sine and cosine of a 30-fraction-bit angle: quadrant reduction and two series chains
`timescale 1ns / 1ps
module afk_sincos #(
    parameter int FRAC_BITS = 16
) (
    input  logic                       clk,
    input  logic                       en,
    input  logic signed [34:0]         angle,
    output logic signed [FRAC_BITS+1:0] sin_out,
    output logic signed [FRAC_BITS+1:0] cos_out
);

    localparam int W  = FRAC_BITS + 2;
    localparam int NT = afk_pkg::SERIES_TERMS;
    localparam int QD = afk_pkg::STEP_LAT * NT;

    localparam logic signed [34:0] H1 = 35'(afk_pkg::Q30_HALF_PI);
    localparam logic signed [34:0] H2 = 35'(2 * afk_pkg::Q30_HALF_PI);
    localparam logic signed [34:0] H3 = 35'(3 * afk_pkg::Q30_HALF_PI);
    localparam logic signed [34:0] T0 = 35'(afk_pkg::Q30_QUARTER_PI);
    localparam logic signed [34:0] T1 = 35'(afk_pkg::Q30_QUARTER_PI + afk_pkg::Q30_HALF_PI);
    localparam logic signed [34:0] T2 = 35'(afk_pkg::Q30_QUARTER_PI
                                            + 2 * afk_pkg::Q30_HALF_PI);

    // Quadrant codes (count of quarter turns removed, modulo four)
    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    logic signed [34:0] off;
    logic        [1:0]  quad_next;
    logic signed [30:0] xr_reg;
    logic        [1:0]  quad_reg;
    logic signed [61:0] sq;
    logic        [30:0] x2_reg;
    logic signed [30:0] xr1_reg;
    logic        [1:0]  qd [QD+1];
    logic signed [32:0] s_term [NT+1];
    logic signed [33:0] s_acc  [NT+1];
    logic        [30:0] s_x2   [NT+1];
    logic signed [32:0] c_term [NT+1];
    logic signed [33:0] c_acc  [NT+1];
    logic        [30:0] c_x2   [NT+1];
    logic signed [W-1:0] sw;
    logic signed [W-1:0] cw;
    logic signed [W-1:0] sin_reg;
    logic signed [W-1:0] cos_reg;

    // Reduce into plus or minus a quarter of pi
    always_comb
    begin
        priority if (angle > T2)
        begin
            off = H3;  quad_next = QUAD_3;
        end
        else if (angle > T1)
        begin
            off = H2;  quad_next = QUAD_2;
        end
        else if (angle > T0)
        begin
            off = H1;  quad_next = QUAD_1;
        end
        else if (angle < -T2)
        begin
            off = -H3; quad_next = QUAD_1;
        end
        else if (angle < -T1)
        begin
            off = -H2; quad_next = QUAD_2;
        end
        else if (angle < -T0)
        begin
            off = -H1; quad_next = QUAD_3;
        end
        else
        begin
            off = '0;  quad_next = QUAD_0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xr_reg   <= 31'(angle - off);
            quad_reg <= quad_next;
        end
    end

    // Square of the reduced angle
    assign sq = 62'(xr_reg) * 62'(xr_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x2_reg  <= 31'((sq + 62'sd536870912) >>> 30);
            xr1_reg <= xr_reg;
            qd[0]   <= quad_reg;
        end
    end

    // Quadrant travels alongside the series
    for (genvar k = 1; k <= QD; k++)
    begin : g_qd
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                qd[k] <= qd[k-1];
            end
        end
    end

    assign s_term[0] = 33'(xr1_reg);
    assign s_acc[0]  = 34'(xr1_reg);
    assign s_x2[0]   = x2_reg;
    assign c_term[0] = 33'(afk_pkg::Q30_ONE);
    assign c_acc[0]  = 34'(afk_pkg::Q30_ONE);
    assign c_x2[0]   = x2_reg;

    for (genvar n = 0; n < NT; n++)
    begin : g_step
        afk_series_step #(.DIV(afk_pkg::SIN_DIV[n])) u_sin (
            .clk      (clk),
            .en       (en),
            .term_in  (s_term[n]),
            .acc_in   (s_acc[n]),
            .x2_in    (s_x2[n]),
            .term_out (s_term[n+1]),
            .acc_out  (s_acc[n+1]),
            .x2_out   (s_x2[n+1])
        );
        afk_series_step #(.DIV(afk_pkg::COS_DIV[n])) u_cos (
            .clk      (clk),
            .en       (en),
            .term_in  (c_term[n]),
            .acc_in   (c_acc[n]),
            .x2_in    (c_x2[n]),
            .term_out (c_term[n+1]),
            .acc_out  (c_acc[n+1]),
            .x2_out   (c_x2[n+1])
        );
    end

    // Bring to the working format, then undo the quadrant reduction
    assign sw = W'(afk_pkg::round_shift64(64'(s_acc[NT]), 30 - FRAC_BITS));
    assign cw = W'(afk_pkg::round_shift64(64'(c_acc[NT]), 30 - FRAC_BITS));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            unique case (qd[QD])
                QUAD_0:
                begin
                    sin_reg <= sw;  cos_reg <= cw;
                end
                QUAD_1:
                begin
                    sin_reg <= cw;  cos_reg <= -sw;
                end
                QUAD_2:
                begin
                    sin_reg <= -sw; cos_reg <= -cw;
                end
                default:
                begin
                    sin_reg <= -cw; cos_reg <= sw;
                end
            endcase
        end
    end

    assign sin_out = sin_reg;
    assign cos_out = cos_reg;

endmodule

>>> rtl/afk_link_cell.sv
// One chain cell: multiplies the running frame by one link transform, or passes it through when bypassed
`timescale 1ns / 1ps
module afk_link_cell #(
    parameter int FRAC_BITS = 16,
    parameter int LINK      = 0
) (
    input  logic                        clk,
    input  logic                        en,
    input  logic                        bypass,
    input  logic signed [FRAC_BITS+1:0] st,
    input  logic signed [FRAC_BITS+1:0] ct,
    input  logic signed [FRAC_BITS+1:0] r_in  [3][3],
    input  logic signed [FRAC_BITS+1:0] p_in  [3],
    output logic signed [FRAC_BITS+1:0] r_out [3][3],
    output logic signed [FRAC_BITS+1:0] p_out [3]
);

    localparam int W  = FRAC_BITS + 2;
    localparam int PW = 2 * W;
    localparam int SW = W + 4;
    localparam int SA = afk_pkg::LINK_SA[LINK];
    localparam int CA = afk_pkg::LINK_CA[LINK];
    // Column that meets the joint's sine and cosine, and its sign
    localparam int XC = (SA == 0) ? 1 : 2;
    localparam int FS = (SA == 0) ? 1 : SA;
    localparam logic signed [W-1:0] A_W =
        W'(afk_pkg::round_shift64(64'(afk_pkg::LINK_A_Q30[LINK]), 30 - FRAC_BITS));
    localparam logic signed [W-1:0] D_W =
        W'(afk_pkg::round_shift64(64'(afk_pkg::LINK_D_Q30[LINK]), 30 - FRAC_BITS));
    localparam logic signed [SW-1:0] MAX_S = SW'((64'sd1 <<< (W - 1)) - 64'sd1);
    localparam logic signed [SW-1:0] MIN_S = -MAX_S - SW'(1);

    logic signed [PW-1:0] prod_reg [3][7];
    logic signed [W:0]    col2_reg [3];
    logic signed [W-1:0]  rin_reg  [3][3];
    logic signed [W-1:0]  pin_reg  [3];
    logic                 byp_reg;
    logic signed [SW-1:0] wr   [3][7];
    logic signed [SW-1:0] sum  [3][4];
    logic signed [W-1:0]  r_reg [3][3];
    logic signed [W-1:0]  p_reg [3];

    function automatic logic signed [W-1:0] sat_w(input logic signed [SW-1:0] x);
        logic signed [W-1:0] y;
        if (x > MAX_S)
        begin
            y = W'(MAX_S);
        end
        else if (x < MIN_S)
        begin
            y = W'(MIN_S);
        end
        else
        begin
            y = W'(x);
        end
        return y;
    endfunction

    // Stage 1: products of the frame rows with the link entries
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                prod_reg[i][0] <= PW'(r_in[i][0])  * PW'(ct);
                prod_reg[i][1] <= PW'(r_in[i][0])  * PW'(st);
                prod_reg[i][2] <= PW'(r_in[i][XC]) * PW'(st);
                prod_reg[i][3] <= PW'(r_in[i][XC]) * PW'(ct);
                prod_reg[i][4] <= PW'(r_in[i][0])  * PW'(A_W);
                prod_reg[i][5] <= PW'(r_in[i][1])  * PW'(D_W);
                prod_reg[i][6] <= PW'(r_in[i][2])  * PW'(D_W);
                col2_reg[i]    <= (W+1)'(r_in[i][2]) * (W+1)'(CA)
                                - (W+1)'(r_in[i][1]) * (W+1)'(SA);
                pin_reg[i]     <= p_in[i];
                for (int j = 0; j < 3; j++)
                begin
                    rin_reg[i][j] <= r_in[i][j];
                end
            end
            byp_reg <= bypass;
        end
    end

    // Stage 2: round each product, sum per entry
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int k = 0; k < 7; k++)
            begin
                wr[i][k] = SW'(afk_pkg::round_shift64(64'(prod_reg[i][k]), FRAC_BITS));
            end
            sum[i][0] = wr[i][0] + SW'(FS) * wr[i][2];
            sum[i][1] = -wr[i][1] + SW'(FS) * wr[i][3];
            sum[i][2] = SW'(col2_reg[i]);
            sum[i][3] = wr[i][4] - SW'(SA) * wr[i][5] + SW'(CA) * wr[i][6]
                      + SW'(pin_reg[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    r_reg[i][j] <= byp_reg ? rin_reg[i][j] : sat_w(sum[i][j]);
                end
                p_reg[i] <= byp_reg ? pin_reg[i] : sat_w(sum[i][3]);
            end
        end
    end

    assign r_out = r_reg;
    assign p_out = p_reg;

endmodule

>>> rtl/arm_forward_kinematics_7dof.sv
// Seven-joint forward kinematics: trig lanes feeding a chain of frame cells
//
//  channel   dir  kind   what moves
//  joints    in   v/r    one item of seven joint angles, Q3.15
//  pose      out  v/r    one item: 3x3 rotation and position, Q2.16
//  apb       in   apb    tool_frame_enable at byte address 0
//
// One item enters per cycle while input ready is high. An accepted item passes
// through 44 register stages, the first at the accepting edge: 24 for sine/cosine
// (reduction, square, seven three-stage series terms, quadrant fold), two per
// chain cell over nine cells, one for output conversion, one for the result buffer.
// The two-entry result buffer lets items keep flowing while a result waits;
// input ready drops only when that buffer is full.
// Reset clears the pipeline valids, the buffer and sets tool_frame_enable.
`timescale 1ns / 1ps
module arm_forward_kinematics_7dof #(
    parameter int FRAC_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    afk_joint_if.sink          joints,
    afk_pose_if.source         pose,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic        [2:0]  paddr,
    input  logic        [31:0] pwdata,
    output logic        [31:0] prdata,
    output logic               pready
);

    localparam int W      = FRAC_BITS + 2;
    localparam int NL     = afk_pkg::NUM_LINKS;
    localparam int NO     = 12;
    localparam int OW     = afk_pkg::OUT_W;
    localparam int DEPTH  = afk_pkg::TRIG_LAT + afk_pkg::CELL_LAT * NL + 1;
    localparam int FIFO_DEPTH = 2;
    localparam int DN_SH  = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
    localparam int UP_SH  = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
    localparam logic signed [63:0] OUT_MAX = 64'sd131071;
    localparam logic signed [63:0] OUT_MIN = -64'sd131072;

    logic                tool_en_reg;
    logic                adv;
    logic [DEPTH-1:0]    vld_reg;
    logic signed [34:0]  ang   [NL];
    logic signed [W-1:0] st_l  [NL];
    logic signed [W-1:0] ct_l  [NL];
    logic signed [W-1:0] r_ch  [NL+1][3][3];
    logic signed [W-1:0] p_ch  [NL+1][3];
    logic signed [W-1:0] fin   [NO];
    logic signed [OW-1:0] conv_reg [NO];
    logic signed [OW-1:0] fifo_reg [FIFO_DEPTH][NO];
    logic                wr_ptr_reg;
    logic                rd_ptr_reg;
    logic [1:0]          cnt_reg;
    logic [1:0]          cnt_next;
    logic                push;
    logic                pop;
    logic                cfg_wr;

    // Configuration port
    assign cfg_wr = psel & penable & pwrite;
    assign pready = 1'b1;
    assign prdata = (paddr[2:2] == 1'(afk_pkg::REG_TOOL_EN)) ? {31'b0, tool_en_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tool_en_reg <= 1'b1;
        end
        else if (cfg_wr && paddr[2:2] == 1'(afk_pkg::REG_TOOL_EN))
        begin
            tool_en_reg <= pwdata[0];
        end
    end

    // Whole pipeline moves while the output buffer has room
    assign adv          = (cnt_reg != 2'(FIFO_DEPTH));
    assign joints.ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[DEPTH-2:0], joints.valid};
        end
    end

    // Angles at 30 fraction bits; flange and hand lanes are fixed
    assign ang[0] = 35'(joints.joint_1_angle) <<< 15;
    assign ang[1] = 35'(joints.joint_2_angle) <<< 15;
    assign ang[2] = 35'(joints.joint_3_angle) <<< 15;
    assign ang[3] = 35'(joints.joint_4_angle) <<< 15;
    assign ang[4] = 35'(joints.joint_5_angle) <<< 15;
    assign ang[5] = 35'(joints.joint_6_angle) <<< 15;
    assign ang[6] = 35'(joints.joint_7_angle) <<< 15;
    assign ang[7] = '0;
    assign ang[8] = 35'(afk_pkg::Q30_HAND_TURN);

    // Identity frame enters the chain
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                r_ch[0][i][j] = (i == j) ? W'(64'sd1 <<< FRAC_BITS) : '0;
            end
            p_ch[0][i] = '0;
        end
    end

    for (genvar l = 0; l < NL; l++)
    begin : g_link
        logic signed [W-1:0] sd [2*l+1];
        logic signed [W-1:0] cd [2*l+1];

        afk_sincos #(.FRAC_BITS(FRAC_BITS)) u_trig (
            .clk     (clk),
            .en      (adv),
            .angle   (ang[l]),
            .sin_out (sd[0]),
            .cos_out (cd[0])
        );

        // Hold the trig pair until its cell's turn in the chain
        for (genvar k = 1; k <= 2 * l; k++)
        begin : g_dly
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    sd[k] <= sd[k-1];
                    cd[k] <= cd[k-1];
                end
            end
        end

        assign st_l[l] = sd[2*l];
        assign ct_l[l] = cd[2*l];

        afk_link_cell #(.FRAC_BITS(FRAC_BITS), .LINK(l)) u_cell (
            .clk    (clk),
            .en     (adv),
            .bypass ((l == afk_pkg::LINK_HAND) ? ~tool_en_reg : 1'b0),
            .st     (st_l[l]),
            .ct     (ct_l[l]),
            .r_in   (r_ch[l]),
            .p_in   (p_ch[l]),
            .r_out  (r_ch[l+1]),
            .p_out  (p_ch[l+1])
        );
    end

    // Output conversion to 16 fraction bits, saturated to 18 bits
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                fin[i*3+j] = r_ch[NL][i][j];
            end
            fin[9+i] = p_ch[NL][i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < NO; k++)
            begin
                logic signed [63:0] v;
                if (FRAC_BITS >= 16)
                begin
                    v = afk_pkg::round_shift64(64'(fin[k]), DN_SH);
                end
                else
                begin
                    v = 64'(fin[k]) <<< UP_SH;
                end
                if (v > OUT_MAX)
                begin
                    conv_reg[k] <= OW'(OUT_MAX);
                end
                else if (v < OUT_MIN)
                begin
                    conv_reg[k] <= OW'(OUT_MIN);
                end
                else
                begin
                    conv_reg[k] <= OW'(v);
                end
            end
        end
    end

    // Two-entry result buffer
    assign push     = adv & vld_reg[DEPTH-1];
    assign pop      = pose.valid & pose.ready;
    assign cnt_next = cnt_reg + 2'(push) - 2'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= conv_reg;
        end
    end

    assign pose.valid         = (cnt_reg != 2'd0);
    assign pose.rot_row0_col0 = fifo_reg[rd_ptr_reg][0];
    assign pose.rot_row0_col1 = fifo_reg[rd_ptr_reg][1];
    assign pose.rot_row0_col2 = fifo_reg[rd_ptr_reg][2];
    assign pose.rot_row1_col0 = fifo_reg[rd_ptr_reg][3];
    assign pose.rot_row1_col1 = fifo_reg[rd_ptr_reg][4];
    assign pose.rot_row1_col2 = fifo_reg[rd_ptr_reg][5];
    assign pose.rot_row2_col0 = fifo_reg[rd_ptr_reg][6];
    assign pose.rot_row2_col1 = fifo_reg[rd_ptr_reg][7];
    assign pose.rot_row2_col2 = fifo_reg[rd_ptr_reg][8];
    assign pose.pos_x         = fifo_reg[rd_ptr_reg][9];
    assign pose.pos_y         = fifo_reg[rd_ptr_reg][10];
    assign pose.pos_z         = fifo_reg[rd_ptr_reg][11];

endmodule

>>> rtl/afk_checker.sv
// Port-level checks for the kinematics block, bound to its top level
`timescale 1ns / 1ps
module afk_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [17:0] out_x,
    input logic [17:0] out_r00,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic [2:0]  paddr,
    input logic [31:0] pwdata,
    input logic [31:0] prdata
);

    // An empty result buffer always takes an item
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with no result pending");

    // A written enable reads back on the next cycle
    a_cfg_readback: assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && !paddr[2]) |=>
        (paddr[2] || prdata[0] == $past(pwdata[0])))
        else $error("tool frame enable readback mismatch");

    // A stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("result withdrawn while stalled");

    // A stalled result keeps its payload
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> ($stable(out_x) && $stable(out_r00)))
        else $error("result payload changed while stalled");

endmodule

bind arm_forward_kinematics_7dof afk_checker u_afk_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (joints.ready),
    .out_valid (pose.valid),
    .out_ready (pose.ready),
    .out_x     (pose.pos_x),
    .out_r00   (pose.rot_row0_col0),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata)
);

>>> test/arm_forward_kinematics_7dof_tb.sv
// Self-checking bench for the seven-joint kinematics block: random joint items against a pose predictor
`timescale 1ns / 1ps
module arm_forward_kinematics_7dof_tb;

    localparam int FB        = 16;
    localparam int N_RANDOM  = 1900;
    localparam int LATENCY   = 43;
    localparam longint LIMIT = 400000;

    typedef logic signed [afk_pkg::ANGLE_W-1:0] angle_t;
    typedef logic signed [afk_pkg::OUT_W-1:0]   outv_t;
    typedef struct {
        outv_t rot [9];
        outv_t pos [3];
    } pose_t;
    typedef struct {
        longint r [3][3];
        longint p [3];
    } frame_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    longint      cycle_count;
    logic        hand_on;
    bit          stall_pat [16];

    afk_joint_if joints ();
    afk_pose_if  pose ();

    arm_forward_kinematics_7dof #(.FRAC_BITS(FB)) u_top (
        .clk(clk), .rst_n(rst_n), .joints(joints), .pose(pose),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // Rounding shift, ties away from zero
    function automatic longint rnd_shift(longint x, int s);
        longint m;
        if (s == 0)
            return x;
        m = (x < 0) ? -x : x;
        m = (m + (64'sd1 <<< (s - 1))) >>> s;
        return (x < 0) ? -m : m;
    endfunction

    function automatic longint sat(longint x, longint lim);
        return (x < -lim) ? -lim : ((x > lim - 1) ? lim - 1 : x);
    endfunction

    // Series sine and cosine at 30 fraction bits with quadrant fold
    function automatic void trig_q30(longint ang, output longint s_o, output longint c_o);
        longint x, x2, t, s, c;
        int k;
        x = ang;
        k = 0;
        while (x > afk_pkg::Q30_QUARTER_PI)
        begin
            x -= afk_pkg::Q30_HALF_PI;
            k++;
        end
        while (x < -afk_pkg::Q30_QUARTER_PI)
        begin
            x += afk_pkg::Q30_HALF_PI;
            k--;
        end
        x2 = rnd_shift(x * x, 30);
        t = x;
        s = x;
        for (int n = 1; n <= 7; n++)
        begin
            t = -(rnd_shift(t * x2, 30) / longint'(2 * n * (2 * n + 1)));
            s += t;
        end
        t = afk_pkg::Q30_ONE;
        c = afk_pkg::Q30_ONE;
        for (int n = 1; n <= 7; n++)
        begin
            t = -(rnd_shift(t * x2, 30) / longint'((2 * n - 1) * 2 * n));
            c += t;
        end
        case (k & 3)
            0: begin s_o = s;  c_o = c;  end
            1: begin s_o = c;  c_o = -s; end
            2: begin s_o = -s; c_o = -c; end
            default: begin s_o = -c; c_o = s; end
        endcase
    endfunction

    function automatic frame_t link_frame(longint a, longint d30, int sa, int ca, longint th);
        frame_t f;
        longint sq, cq, st, ct, d, one;
        one = 64'sd1 <<< FB;
        trig_q30(th, sq, cq);
        st = rnd_shift(sq, 30 - FB);
        ct = rnd_shift(cq, 30 - FB);
        d  = rnd_shift(d30, 30 - FB);
        f.r[0][0] = ct;      f.r[0][1] = -st;     f.r[0][2] = 0;
        f.r[1][0] = st * ca; f.r[1][1] = ct * ca; f.r[1][2] = -sa * one;
        f.r[2][0] = st * sa; f.r[2][1] = ct * sa; f.r[2][2] = ca * one;
        f.p[0] = rnd_shift(a, 30 - FB);
        f.p[1] = -sa * d;
        f.p[2] = ca * d;
        return f;
    endfunction

    function automatic frame_t chain(frame_t x, frame_t y);
        frame_t z;
        longint lim;
        lim = 64'sd1 <<< (FB + 1);
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
                z.r[i][j] = sat(rnd_shift(x.r[i][0] * y.r[0][j], FB)
                              + rnd_shift(x.r[i][1] * y.r[1][j], FB)
                              + rnd_shift(x.r[i][2] * y.r[2][j], FB), lim);
            z.p[i] = sat(rnd_shift(x.r[i][0] * y.p[0], FB) + rnd_shift(x.r[i][1] * y.p[1], FB)
                       + rnd_shift(x.r[i][2] * y.p[2], FB) + x.p[i], lim);
        end
        return z;
    endfunction

    // End frame pose for one set of joint angles
    function automatic pose_t end_pose(angle_t ang [7], logic hand);
        frame_t acc, lk;
        pose_t res;
        for (int i = 0; i < afk_pkg::NUM_JOINTS; i++)
        begin
            lk = link_frame(afk_pkg::LINK_A_Q30[i], afk_pkg::LINK_D_Q30[i],
                            afk_pkg::LINK_SA[i], afk_pkg::LINK_CA[i],
                            longint'(ang[i]) * 32768);
            acc = (i == 0) ? lk : chain(acc, lk);
        end
        acc = chain(acc, link_frame(0, afk_pkg::LINK_D_Q30[afk_pkg::NUM_JOINTS], 0, 1, 0));
        if (hand)
            acc = chain(acc, link_frame(0, afk_pkg::LINK_D_Q30[afk_pkg::LINK_HAND], 0, 1,
                                        afk_pkg::Q30_HAND_TURN));
        for (int i = 0; i < 9; i++)
            res.rot[i] = outv_t'(sat(rnd_shift(acc.r[i / 3][i % 3], FB - 16), 131072));
        for (int i = 0; i < 3; i++)
            res.pos[i] = outv_t'(sat(rnd_shift(acc.p[i], FB - 16), 131072));
        return res;
    endfunction

    class pose_board;
        pose_t pending [$];
        int    errors;
        int    seen;

        function void note_joints(angle_t ang [7], logic hand);
            pending = {pending, end_pose(ang, hand)};
        endfunction

        function void check_pose(pose_t got);
            pose_t want;
            bit    bad;
            seen++;
            if (pending.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected pose item at cycle %0d", cycle_count);
                return;
            end
            want = pending.pop_front();
            bad = 0;
            for (int i = 0; i < 9; i++)
                if (got.rot[i] !== want.rot[i])
                begin
                    bad = 1;
                    if (errors < 10)
                        $display("pose %0d rot[%0d]: expected %0d, got %0d",
                                 seen, i, want.rot[i], got.rot[i]);
                end
            for (int i = 0; i < 3; i++)
                if (got.pos[i] !== want.pos[i])
                begin
                    bad = 1;
                    if (errors < 10)
                        $display("pose %0d pos[%0d]: expected %0d, got %0d",
                                 seen, i, want.pos[i], got.pos[i]);
                end
            if (bad)
                errors++;
        endfunction
    endclass

    pose_board board;

    // Clock
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    // Result side: stall pattern and checking
    always @(posedge clk)
    begin
        pose_t got;
        if (rst_n)
        begin
            if (pose.valid && pose.ready)
            begin
                got.rot = '{pose.rot_row0_col0, pose.rot_row0_col1, pose.rot_row0_col2,
                            pose.rot_row1_col0, pose.rot_row1_col1, pose.rot_row1_col2,
                            pose.rot_row2_col0, pose.rot_row2_col1, pose.rot_row2_col2};
                got.pos = '{pose.pos_x, pose.pos_y, pose.pos_z};
                board.check_pose(got);
            end
            pose.ready <= stall_pat[cycle_count % 16];
        end
    end

    // Register write; only the enable register changes the predicted chain
    task automatic reg_write(logic [2:0] addr, logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr[2] == 1'(afk_pkg::REG_TOOL_EN))
            hand_on = data[0];
    endtask

    // Hold one item on the channel until accepted; idle cycles before it
    task automatic send_joints(angle_t ang [7], int gap);
        repeat (gap)
        begin
            joints.valid <= 1'b0;
            @(posedge clk);
        end
        joints.valid <= 1'b1;
        joints.joint_1_angle <= ang[0];
        joints.joint_2_angle <= ang[1];
        joints.joint_3_angle <= ang[2];
        joints.joint_4_angle <= ang[3];
        joints.joint_5_angle <= ang[4];
        joints.joint_6_angle <= ang[5];
        joints.joint_7_angle <= ang[6];
        @(posedge clk);
        while (!joints.ready)
            @(posedge clk);
        board.note_joints(ang, hand_on);
    endtask

    task automatic drain();
        joints.valid <= 1'b0;
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 5)
            @(posedge clk);
    endtask

    function automatic angle_t rand_angle(int mode);
        case (mode)
            0: return angle_t'($urandom_range(0, 262143));
            1: return angle_t'($signed(18'($urandom_range(0, 103000))) - 51500);
            default: return angle_t'($signed(18'($urandom_range(0, 8000))) - 4000);
        endcase
    endfunction

    task automatic random_phase(int count);
        angle_t ang [7];
        int burst, gap, mode;
        burst = 0;
        for (int n = 0; n < count; n++)
        begin
            gap = 0;
            if (burst == 0)
            begin
                burst = $urandom_range(1, 40);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                for (int i = 0; i < 16; i++)
                    stall_pat[i] = ($urandom_range(0, 3) != 0) || (n < count / 5);
            end
            burst--;
            mode = $urandom_range(0, 2);
            for (int i = 0; i < 7; i++)
                ang[i] = rand_angle(mode);
            send_joints(ang, gap);
        end
    endtask

    initial
    begin
        angle_t ang [7];
        angle_t corner [6];
        board = new();
        cycle_count = 0;
        hand_on = 1'b1;
        rst_n   = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        joints.valid = 1'b0;
        joints.joint_1_angle = '0;
        joints.joint_2_angle = '0;
        joints.joint_3_angle = '0;
        joints.joint_4_angle = '0;
        joints.joint_5_angle = '0;
        joints.joint_6_angle = '0;
        joints.joint_7_angle = '0;
        pose.ready = 1'b1;
        for (int i = 0; i < 16; i++)
            stall_pat[i] = 1'b1;
        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset setting, extreme angles, quadrant edges
        corner = '{angle_t'(0), angle_t'(-131072), angle_t'(131071),
                   angle_t'(51472), angle_t'(-51472), angle_t'(25736)};
        for (int c = 0; c < 6; c++)
        begin
            for (int i = 0; i < 7; i++)
                ang[i] = corner[c];
            send_joints(ang, 0);
        end
        for (int j = 0; j < 7; j++)
        begin
            for (int i = 0; i < 7; i++)
                ang[i] = (i == j) ? angle_t'(-131072) : angle_t'(131071);
            send_joints(ang, j % 2);
        end
        drain();

        // Hand frame off; stray bits above bit 0 and unmapped address ignored
        reg_write(3'(4 * afk_pkg::REG_TOOL_EN), 32'hFFFF_FFFE);
        reg_write(3'(4 * (afk_pkg::REG_TOOL_EN + 1)), 32'h0000_0001);
        for (int c = 0; c < 6; c++)
        begin
            for (int i = 0; i < 7; i++)
                ang[i] = corner[c];
            send_joints(ang, 0);
        end
        random_phase(N_RANDOM / 2);
        drain();

        reg_write(3'(4 * afk_pkg::REG_TOOL_EN), 32'h0000_0001);
        random_phase(N_RANDOM / 2);
        drain();

        $display("covered %0d pose items over both hand frame settings, angles at full range",
                 board.seen);
        if (board.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Watchdog
    initial
    begin
        wait (cycle_count >= LIMIT);
        $display("timeout after %0d cycles", cycle_count);
        $display("status: fail");
        $finish;
    end

endmodule
